// ===== hdl/rcsa_pkg.sv =====
// ----------------------------------------------------------------------------
// rcsa_pkg
// Shared types and constants of the row contiguous slot allocator.
// ----------------------------------------------------------------------------
package rcsa_pkg;

    // Defaults of the top level parameters
    localparam int SLOTS_PER_ROW_DEF = 16;
    localparam int MAX_ROWS_DEF      = 16;
    localparam int OWNER_BITS_DEF    = 16;

    // Fixed field widths
    localparam int COUNT_W    = 5;
    localparam int OWNER_ID_W = 16;
    localparam int SLOT_W     = 8;
    localparam int FREE_W     = 9;
    localparam int ROWS_CFG_W = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int FREE_MAX   = 511;

    // Stream packing
    localparam int S_DATA_W = 32;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 24;
    localparam int M_USER_W = 2;

    localparam logic ACT_RESERVE = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_B = 1'b1;

    typedef enum logic [1:0] {
        STAT_RESERVED = 2'd0,
        STAT_FAILED   = 2'd1,
        STAT_RELEASED = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ES_CLEAR,
        ES_IDLE,
        ES_SCAN,
        ES_FILL,
        ES_REL,
        ES_DONE
    } eng_state_t;

    typedef struct packed {
        logic               action;
        logic               zone;
        logic [COUNT_W-1:0] count;
        logic [SLOT_W-1:0]  first;
        logic               pre_fail;
    } cmd_t;

    typedef struct packed {
        status_t            status;
        logic [SLOT_W-1:0]  granted;
        logic [COUNT_W-1:0] adj;
    } res_t;

endpackage

// ===== hdl/rcsa_slot_mem.sv =====
// ----------------------------------------------------------------------------
// rcsa_slot_mem
// Slot owner table: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rcsa_slot_mem #(
    parameter int DEPTH = 2 * rcsa_pkg::MAX_ROWS_DEF * rcsa_pkg::SLOTS_PER_ROW_DEF,
    parameter int DW    = rcsa_pkg::OWNER_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DW-1:0]            rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DW-1:0]            wr_data
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hdl/rcsa_engine.sv =====
// ----------------------------------------------------------------------------
// rcsa_engine
// Sequencer around one index counter and slot compare: clears the table
// after reset, scans rows for a free run, fills it, and frees released runs.
// ----------------------------------------------------------------------------
module rcsa_engine #(
    parameter int SLOTS_PER_ROW = rcsa_pkg::SLOTS_PER_ROW_DEF,
    parameter int MAX_ROWS      = rcsa_pkg::MAX_ROWS_DEF,
    parameter int OWNER_BITS    = rcsa_pkg::OWNER_BITS_DEF
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        start,
    input  rcsa_pkg::cmd_t                              cmd,
    input  logic [OWNER_BITS-1:0]                       owner,
    input  logic [$clog2(MAX_ROWS*SLOTS_PER_ROW+1)-1:0] limit,
    output logic                                        idle,
    output logic                                        res_valid,
    input  logic                                        res_ready,
    output rcsa_pkg::res_t                              res
);
    import rcsa_pkg::*;

    localparam int ZS    = MAX_ROWS * SLOTS_PER_ROW;
    localparam int DEPTH = 2 * ZS;
    localparam int IW    = $clog2(ZS + 1);
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = (IW > SLOT_W + 1) ? IW : SLOT_W + 1;
    localparam int XW    = PW + 1;
    localparam int CLW   = (SLOTS_PER_ROW > 1) ? $clog2(SLOTS_PER_ROW) : 1;
    localparam int CW    = $clog2(SLOTS_PER_ROW + 1);
    localparam int RUNW  = (CW > COUNT_W) ? CW : COUNT_W;

    eng_state_t             state_reg, state_next;
    logic [AW-1:0]          clr_reg, clr_next;
    logic [PW-1:0]          ptr_reg, ptr_next;
    logic [PW-1:0]          end_reg, end_next;
    logic [CLW-1:0]         col_reg, col_next;
    logic [RUNW-1:0]        run_reg, run_next;
    logic                   chk_vld_reg, chk_vld_next;
    logic                   chk_first_reg, chk_first_next;
    logic                   chk_in_reg, chk_in_next;
    logic [PW-1:0]          chk_ptr_reg, chk_ptr_next;
    logic [AW-1:0]          chk_addr_reg, chk_addr_next;
    logic [COUNT_W-1:0]     fill_left_reg, fill_left_next;
    logic [COUNT_W-1:0]     freed_reg, freed_next;
    logic                   zone_reg, zone_next;
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic [OWNER_BITS-1:0]  owner_reg, owner_next;
    res_t                   res_reg, res_next;

    logic                   rd_en;
    logic [AW-1:0]          rd_addr;
    logic [OWNER_BITS-1:0]  rd_data;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [OWNER_BITS-1:0]  wr_data;

    logic [AW-1:0]          zone_off;
    logic [AW-1:0]          issue_addr;
    logic                   more;
    logic                   in_zone;
    logic                   slot_free;
    logic [RUNW-1:0]        run_new;
    logic                   hit;
    logic                   walk_end;
    logic [XW-1:0]          start_x;
    logic [PW-1:0]          start_ptr;
    logic                   rel_clear;
    logic                   clr_last;

    rcsa_slot_mem #(
        .DEPTH (DEPTH),
        .DW    (OWNER_BITS)
    ) u_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // Shared index and compare unit
    assign zone_off   = zone_reg ? AW'(ZS) : '0;
    assign issue_addr = zone_off + AW'(ptr_reg);
    assign more       = ptr_reg < end_reg;
    assign in_zone    = ptr_reg < PW'(ZS);
    assign slot_free  = (rd_data == '0);
    assign run_new    = slot_free ? ((chk_first_reg ? '0 : run_reg) + RUNW'(1)) : '0;
    assign hit        = (state_reg == ES_SCAN) && chk_vld_reg && slot_free
                        && (run_new == RUNW'(count_reg));
    assign walk_end   = !chk_vld_reg && !more;
    assign start_x    = XW'(chk_ptr_reg) + XW'(1) - XW'(count_reg);
    assign start_ptr  = PW'(start_x);
    assign rel_clear  = (state_reg == ES_REL) && chk_vld_reg && chk_in_reg && !slot_free;
    assign clr_last   = (clr_reg == AW'(DEPTH - 1));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ES_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = ES_IDLE;
                end
            end
            ES_IDLE:
            begin
                if (start)
                begin
                    if (cmd.pre_fail)
                    begin
                        state_next = ES_DONE;
                    end
                    else if (cmd.action == ACT_RESERVE)
                    begin
                        state_next = ES_SCAN;
                    end
                    else
                    begin
                        state_next = ES_REL;
                    end
                end
            end
            ES_SCAN:
            begin
                if (hit)
                begin
                    state_next = ES_FILL;
                end
                else if (walk_end)
                begin
                    state_next = ES_DONE;
                end
            end
            ES_FILL:
            begin
                if (fill_left_reg == COUNT_W'(1))
                begin
                    state_next = ES_DONE;
                end
            end
            ES_REL:
            begin
                if (walk_end)
                begin
                    state_next = ES_DONE;
                end
            end
            ES_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ES_IDLE;
                end
            end
            default:
            begin
                state_next = ES_IDLE;
            end
        endcase
    end

    // Outputs and memory port control
    always_comb
    begin
        idle      = (state_reg == ES_IDLE);
        res_valid = (state_reg == ES_DONE);
        res       = res_reg;
        rd_en     = ((state_reg == ES_SCAN) || (state_reg == ES_REL))
                    && more && in_zone && !hit;
        rd_addr   = issue_addr;
        wr_en     = 1'b0;
        wr_addr   = clr_reg;
        wr_data   = '0;
        unique case (state_reg)
            ES_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_reg;
            end
            ES_FILL:
            begin
                wr_en   = 1'b1;
                wr_addr = issue_addr;
                wr_data = owner_reg;
            end
            ES_REL:
            begin
                wr_en   = rel_clear;
                wr_addr = chk_addr_reg;
            end
            ES_IDLE, ES_SCAN, ES_DONE:
            begin
                wr_en = 1'b0;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    // Datapath
    always_comb
    begin
        clr_next       = clr_reg;
        ptr_next       = ptr_reg;
        end_next       = end_reg;
        col_next       = col_reg;
        run_next       = run_reg;
        chk_vld_next   = chk_vld_reg;
        chk_first_next = chk_first_reg;
        chk_in_next    = chk_in_reg;
        chk_ptr_next   = chk_ptr_reg;
        chk_addr_next  = chk_addr_reg;
        fill_left_next = fill_left_reg;
        freed_next     = freed_reg;
        zone_next      = zone_reg;
        count_next     = count_reg;
        owner_next     = owner_reg;
        res_next       = res_reg;

        unique case (state_reg)
            ES_CLEAR:
            begin
                clr_next = clr_reg + AW'(1);
            end
            ES_IDLE:
            begin
                if (start)
                begin
                    zone_next    = cmd.zone;
                    count_next   = cmd.count;
                    owner_next   = owner;
                    run_next     = '0;
                    col_next     = '0;
                    chk_vld_next = 1'b0;
                    freed_next   = '0;
                    res_next     = '{status: STAT_FAILED, granted: '0, adj: '0};
                    if (cmd.action == ACT_RESERVE)
                    begin
                        ptr_next = '0;
                        end_next = PW'(limit);
                    end
                    else
                    begin
                        ptr_next = PW'(cmd.first);
                        end_next = PW'(cmd.first) + PW'(cmd.count);
                    end
                end
            end
            ES_SCAN, ES_REL:
            begin
                // Issue stage
                chk_vld_next   = more;
                chk_first_next = (col_reg == '0);
                chk_in_next    = in_zone;
                chk_ptr_next   = ptr_reg;
                chk_addr_next  = issue_addr;
                if (more)
                begin
                    ptr_next = ptr_reg + PW'(1);
                    col_next = (col_reg == CLW'(SLOTS_PER_ROW - 1)) ? '0 : col_reg + CLW'(1);
                end
                // Check stage
                if (state_reg == ES_SCAN)
                begin
                    if (chk_vld_reg)
                    begin
                        run_next = run_new;
                    end
                    if (hit)
                    begin
                        ptr_next        = start_ptr;
                        fill_left_next  = count_reg;
                        res_next.granted = SLOT_W'(start_ptr);
                    end
                end
                else
                begin
                    if (rel_clear)
                    begin
                        freed_next = freed_reg + COUNT_W'(1);
                    end
                    if (walk_end)
                    begin
                        res_next.status = STAT_RELEASED;
                        res_next.adj    = freed_reg;
                    end
                end
            end
            ES_FILL:
            begin
                ptr_next       = ptr_reg + PW'(1);
                fill_left_next = fill_left_reg - COUNT_W'(1);
                if (fill_left_reg == COUNT_W'(1))
                begin
                    res_next.status = STAT_RESERVED;
                    res_next.adj    = count_reg;
                end
            end
            ES_DONE:
            begin
                chk_vld_next = 1'b0;
            end
            default:
            begin
                chk_vld_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ES_CLEAR;
            clr_reg     <= '0;
            chk_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            chk_vld_reg <= chk_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg       <= ptr_next;
        end_reg       <= end_next;
        col_reg       <= col_next;
        run_reg       <= run_next;
        chk_first_reg <= chk_first_next;
        chk_in_reg    <= chk_in_next;
        chk_ptr_reg   <= chk_ptr_next;
        chk_addr_reg  <= chk_addr_next;
        fill_left_reg <= fill_left_next;
        freed_reg     <= freed_next;
        zone_reg      <= zone_next;
        count_reg     <= count_next;
        owner_reg     <= owner_next;
        res_reg       <= res_next;
    end

    a_fill_inside: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ES_FILL) |-> (ptr_reg < end_reg))
        else $error("fill runs past the rows in use");

    a_hit_fills: assert property (@(posedge clk) disable iff (!rst_n)
        hit |=> (state_reg == ES_FILL))
        else $error("found run not filled");

    a_port_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("read and write hit the same slot");

endmodule

// ===== hdl/row_contiguous_slot_allocator.sv =====
// ----------------------------------------------------------------------------
// row_contiguous_slot_allocator
// First-fit allocator of contiguous slot runs within table rows, two zones.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tuser: action, zone
//                                               tdata: count, owner_id, first_slot
// m_axis    out  m_axis_tvalid / m_axis_tready  tuser: status
//                                               tdata: granted_first, free_left
// cfg       in   cfg_valid / cfg_ready          cfg_index, cfg_data (rows per zone)
//
// A reserve walks the rows in use one slot per cycle through the single table
// read port until a run fits, then fills that run; a release walks only the
// released slots, and an up-front fail goes straight to the result. After reset
// the table is cleared one slot a cycle; items wait, configuration is taken.
// One item is in work at a time. A finished result sits in the output
// register, so the next item is accepted while it waits on m_axis_tready;
// a second finished result holds the engine and stalls the input.
//
module row_contiguous_slot_allocator #(
    parameter int SLOTS_PER_ROW = rcsa_pkg::SLOTS_PER_ROW_DEF,
    parameter int MAX_ROWS      = rcsa_pkg::MAX_ROWS_DEF,
    parameter int OWNER_BITS    = rcsa_pkg::OWNER_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // count[4:0], owner_id[20:5], first_slot[28:21], zero fill
    input  logic [rcsa_pkg::S_DATA_W-1:0]      s_axis_tdata,
    // action[0], zone[1]
    input  logic [rcsa_pkg::S_USER_W-1:0]      s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // granted_first[7:0], free_left[16:8], zero fill
    output logic [rcsa_pkg::M_DATA_W-1:0]      m_axis_tdata,
    // status[1:0]
    output logic [rcsa_pkg::M_USER_W-1:0]      m_axis_tuser,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rcsa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rcsa_pkg::ROWS_CFG_W-1:0]    cfg_data
);
    import rcsa_pkg::*;

    localparam int ZS       = MAX_ROWS * SLOTS_PER_ROW;
    localparam int IW       = $clog2(ZS + 1);
    localparam int RW       = $clog2(MAX_ROWS + 1);
    localparam int FREE_RST = (ZS > FREE_MAX) ? FREE_MAX : ZS;

    // Unpacked input fields
    logic                     in_action;
    logic                     in_zone;
    logic [COUNT_W-1:0]       in_count;
    logic [OWNER_ID_W-1:0]    in_owner_id;
    logic [SLOT_W-1:0]        in_first;

    logic [RW-1:0]            rows_a_reg, rows_a_next;
    logic [RW-1:0]            rows_b_reg, rows_b_next;
    logic [FREE_W-1:0]        free_a_reg, free_a_next;
    logic [FREE_W-1:0]        free_b_reg, free_b_next;
    logic                     cur_zone_reg, cur_zone_next;
    logic                     out_valid_reg, out_valid_next;
    status_t                  out_status_reg, out_status_next;
    logic [SLOT_W-1:0]        out_granted_reg, out_granted_next;
    logic [FREE_W-1:0]        out_free_reg, out_free_next;

    logic [RW-1:0]            cfg_rows;
    logic [FREE_W-1:0]        cfg_reload;
    logic [OWNER_BITS+OWNER_ID_W-1:0] owner_ext;
    logic [OWNER_BITS-1:0]    owner_m;
    logic [RW-1:0]            rows_sel;
    logic [FREE_W-1:0]        free_sel;
    logic [FREE_W-1:0]        free_cur;
    logic [FREE_W:0]          free_sum;
    logic [FREE_W-1:0]        free_new;
    logic [IW-1:0]            limit;
    logic                     eng_idle;
    logic                     start;
    cmd_t                     cmd;
    logic                     res_valid;
    logic                     res_take;
    res_t                     res;

    assign in_count    = s_axis_tdata[4:0];
    assign in_owner_id = s_axis_tdata[20:5];
    assign in_first    = s_axis_tdata[28:21];
    assign in_action   = s_axis_tuser[0];
    assign in_zone     = s_axis_tuser[1];

    // Configuration: rows saturate at MAX_ROWS, the free counter reloads
    assign cfg_ready  = 1'b1;
    assign cfg_rows   = (int'(cfg_data) > MAX_ROWS) ? RW'(MAX_ROWS) : RW'(cfg_data);
    assign cfg_reload = ((int'(cfg_rows) * SLOTS_PER_ROW) > FREE_MAX)
                        ? FREE_W'(FREE_MAX)
                        : FREE_W'(int'(cfg_rows) * SLOTS_PER_ROW);

    // Owner masked to the stored width; zero means no owner
    assign owner_ext = {{OWNER_BITS{1'b0}}, in_owner_id};
    assign owner_m   = owner_ext[OWNER_BITS-1:0];

    assign rows_sel = in_zone ? rows_b_reg : rows_a_reg;
    assign free_sel = in_zone ? free_b_reg : free_a_reg;
    assign limit    = IW'(int'(rows_sel) * SLOTS_PER_ROW);

    // Accept whenever the engine is idle; the output register decouples
    assign s_axis_tready = eng_idle;
    assign start         = s_axis_tvalid && eng_idle;

    // Drop at once: zero count, or for a reserve a zero owner or too few free slots in the zone
    always_comb
    begin
        cmd.action   = in_action;
        cmd.zone     = in_zone;
        cmd.count    = in_count;
        cmd.first    = in_first;
        cmd.pre_fail = (in_count == '0)
                       || ((in_action == ACT_RESERVE)
                           && ((owner_m == '0) || (free_sel < FREE_W'(in_count))));
    end

    rcsa_engine #(
        .SLOTS_PER_ROW (SLOTS_PER_ROW),
        .MAX_ROWS      (MAX_ROWS),
        .OWNER_BITS    (OWNER_BITS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (cmd),
        .owner     (owner_m),
        .limit     (limit),
        .idle      (eng_idle),
        .res_valid (res_valid),
        .res_ready (res_take),
        .res       (res)
    );

    // Take a result when the output register is empty or being drained
    assign res_take = res_valid && (!out_valid_reg || m_axis_tready);

    // Free counter update: subtract a grant, add freed slots with saturation
    assign free_cur = cur_zone_reg ? free_b_reg : free_a_reg;
    assign free_sum = {1'b0, free_cur} + (FREE_W + 1)'(res.adj);
    always_comb
    begin
        unique case (res.status)
            STAT_RESERVED:
            begin
                free_new = free_cur - FREE_W'(res.adj);
            end
            STAT_RELEASED:
            begin
                free_new = (free_sum > (FREE_W + 1)'(FREE_MAX))
                           ? FREE_W'(FREE_MAX) : free_sum[FREE_W-1:0];
            end
            STAT_FAILED:
            begin
                free_new = free_cur;
            end
            default:
            begin
                free_new = free_cur;
            end
        endcase
    end

    always_comb
    begin
        rows_a_next      = rows_a_reg;
        rows_b_next      = rows_b_reg;
        free_a_next      = free_a_reg;
        free_b_next      = free_b_reg;
        cur_zone_next    = cur_zone_reg;
        out_valid_next   = out_valid_reg;
        out_status_next  = out_status_reg;
        out_granted_next = out_granted_reg;
        out_free_next    = out_free_reg;

        if (start)
        begin
            cur_zone_next = in_zone;
        end

        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (res_take)
        begin
            out_valid_next   = 1'b1;
            out_status_next  = res.status;
            out_granted_next = (res.status == STAT_RESERVED) ? res.granted : '0;
            out_free_next    = free_new;
            if (cur_zone_reg)
            begin
                free_b_next = free_new;
            end
            else
            begin
                free_a_next = free_new;
            end
        end

        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_ROWS_A:
                begin
                    rows_a_next = cfg_rows;
                    free_a_next = cfg_reload;
                end
                CFG_ROWS_B:
                begin
                    rows_b_next = cfg_rows;
                    free_b_next = cfg_reload;
                end
                default:
                begin
                    rows_a_next = rows_a_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg    <= RW'(MAX_ROWS);
            rows_b_reg    <= RW'(MAX_ROWS);
            free_a_reg    <= FREE_W'(FREE_RST);
            free_b_reg    <= FREE_W'(FREE_RST);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rows_a_reg    <= rows_a_next;
            rows_b_reg    <= rows_b_next;
            free_a_reg    <= free_a_next;
            free_b_reg    <= free_b_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_zone_reg    <= cur_zone_next;
        out_status_reg  <= out_status_next;
        out_granted_reg <= out_granted_next;
        out_free_reg    <= out_free_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {(M_DATA_W - SLOT_W - FREE_W)'(0), out_free_reg, out_granted_reg};

endmodule
